// ===== hw/rtl/vending_purchase_with_change_top_defines.svh =====
// Assertion macros shared by the RTL of the vending block.
`ifndef VENDING_PURCHASE_WITH_CHANGE_TOP_DEFINES_SVH
`define VENDING_PURCHASE_WITH_CHANGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define VPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpc: assertion failed");

// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define VPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpc: assertion failed");

`endif

// ===== hw/rtl/vpc_pkg.sv =====
package vpc_pkg;

  localparam int NUM_PRODUCTS  = 7;
  localparam int INITIAL_STOCK = 10;
  localparam int NUM_DENOM     = 9;

  localparam int IDX_W       = 3;
  localparam int CENTS_W     = 16;
  localparam int COIN_W      = 11;
  localparam int COUNT_W     = 6;
  localparam int STOCK_W     = 8;
  localparam int DENOM_IDX_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_COIN   = 1'b1;

  // Purchase status codes
  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_FIRST   = 3'd1;

  localparam logic [IDX_W-1:0]   PRODUCT_COUNT_RESET = 3'd3;
  localparam logic [CENTS_W-1:0] PRICE_RESET [NUM_PRODUCTS] =
    '{16'd1050, 16'd575, 16'd820, 16'd0, 16'd0, 16'd0, 16'd0};

  typedef struct packed {
    logic [IDX_W-1:0]   product_index;
    logic [CENTS_W-1:0] paid_cents;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic [1:0]         status;
    logic [CENTS_W-1:0] change_cents;
    logic [COIN_W-1:0]  coin_cents;
    logic [COUNT_W-1:0] coin_count;
    logic               last;
  } out_item_t;

  // Request from the controller to the change unit
  typedef struct packed {
    logic               start;
    logic [CENTS_W-1:0] change;
  } coin_req_t;

  // One coin line from the change unit
  typedef struct packed {
    logic               valid;
    logic [COIN_W-1:0]  cents;
    logic [COUNT_W-1:0] count;
    logic               last;
  } coin_line_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_EMIT
  } coin_state_t;

  // Denominations in descending value order
  function automatic logic [COIN_W-1:0] denom_value(input logic [DENOM_IDX_W-1:0] di);
    logic [COIN_W-1:0] v;
    case (di)
      4'd0:    v = 11'd2000;
      4'd1:    v = 11'd1000;
      4'd2:    v = 11'd500;
      4'd3:    v = 11'd100;
      4'd4:    v = 11'd50;
      4'd5:    v = 11'd25;
      4'd6:    v = 11'd10;
      4'd7:    v = 11'd5;
      4'd8:    v = 11'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/vpc_stock_mem.sv =====
module vpc_stock_mem import vpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [STOCK_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [STOCK_W-1:0] wr_data
);

  logic [STOCK_W-1:0] stock_mem_r [NUM_PRODUCTS];
  logic [NUM_PRODUCTS-1:0] valid_r;
  logic [STOCK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stock_mem_r[wr_addr] <= wr_data;
    end
  end

  // An entry never written reads as the initial stock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? stock_mem_r[rd_addr] : STOCK_W'(INITIAL_STOCK);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/vpc_change_unit.sv =====
module vpc_change_unit import vpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  coin_req_t  req,
  output coin_line_t line
);

  coin_state_t             state_r, state_nxt;
  logic [CENTS_W-1:0]      rest_r, rest_nxt;
  logic [DENOM_IDX_W-1:0]  di_r, di_nxt;
  logic [DENOM_IDX_W-1:0]  top_r, top_nxt;
  logic                    found_r, found_nxt;
  logic [COUNT_W-1:0]      counts_r [NUM_DENOM];

  logic [COUNT_W-1:0]      quot;
  logic [CENTS_W-1:0]      rest_div;
  logic                    div_last;
  logic                    cnt_we;

  localparam logic [DENOM_IDX_W-1:0] DI_LAST = DENOM_IDX_W'(NUM_DENOM - 1);

  // Restoring division of the remainder by the current denomination
  always_comb begin
    logic [CENTS_W:0] rem;
    logic [CENTS_W:0] sh;
    rem  = {1'b0, rest_r};
    quot = '0;
    for (int b = COUNT_W - 1; b >= 0; b--) begin
      sh = (CENTS_W + 1)'(denom_value(di_r)) << b;
      if (rem >= sh) begin
        rem     = rem - sh;
        quot[b] = 1'b1;
      end
    end
    rest_div = rem[CENTS_W-1:0];
  end

  assign div_last = (di_r == DI_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (req.start) state_nxt = C_DIV;
      C_DIV:  if (div_last) state_nxt = C_EMIT;
      C_EMIT: if (di_r == top_r) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rest_nxt   = rest_r;
    di_nxt     = di_r;
    top_nxt    = top_r;
    found_nxt  = found_r;
    cnt_we     = 1'b0;
    line       = '0;
    unique case (state_r)
      C_IDLE: begin
        if (req.start) begin
          rest_nxt  = req.change;
          di_nxt    = '0;
          found_nxt = 1'b0;
        end
      end
      C_DIV: begin
        cnt_we   = 1'b1;
        rest_nxt = rest_div;
        if (quot != '0 && !found_r) begin
          top_nxt   = di_r;
          found_nxt = 1'b1;
        end
        if (!div_last) di_nxt = di_r + 1'b1;
      end
      C_EMIT: begin
        line.valid = (counts_r[di_r] != '0);
        line.cents = denom_value(di_r);
        line.count = counts_r[di_r];
        line.last  = (di_r == top_r);
        if (di_r != top_r) di_nxt = di_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    di_r   <= di_nxt;
    top_r  <= top_nxt;
    if (cnt_we) counts_r[di_r] <= quot;
  end

endmodule

// ===== hw/rtl/vending_purchase_with_change_top.sv =====
// Channel   Ports                          Transaction taken when
// input     start, busy, in_data           start high and busy low at a clk edge
// result    out_valid, out_data            out_valid high (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_wdata   cfg_we high at a clk edge
//
// The stock memory is read in the cycle of acceptance; its data is evaluated in
// the next cycle, and the status result shows in the cycle after that.
// Not found, refused and exact payment give the status result alone; with change,
// the change unit then works out one denomination per cycle through one
// compare-subtract divider, then scans the coin counts for the coin result lines.
// Synchronous active-low reset restores the state and config registers and marks all
// stock entries as initial stock. The receiver cannot stall: results just go out.
`include "vending_purchase_with_change_top_defines.svh"

module vending_purchase_with_change_top import vpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [CENTS_W-1:0] paid_r;
  logic [IDX_W-1:0]   pcount_r;
  logic [CENTS_W-1:0] price_r [NUM_PRODUCTS];

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               rd_en;
  logic [STOCK_W-1:0] stock;
  logic               wr_en;
  logic [CENTS_W-1:0] price_sel;
  logic               not_found;
  logic               refused;
  logic [CENTS_W-1:0] change;
  coin_req_t          coin_req;
  coin_line_t         coin_line;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Skip the memory read for an index past the table; it is not found anyway.
  assign rd_en = accept && (in_data.product_index < IDX_W'(NUM_PRODUCTS));

  vpc_stock_mem u_stock (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_data.product_index),
    .rd_data (stock),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (stock - 1'b1)
  );

  vpc_change_unit u_change (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (coin_req),
    .line  (coin_line)
  );

  // Configuration registers: to be written only while idle; the user must keep to this, the block does no check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= PRODUCT_COUNT_RESET;
      for (int i = 0; i < NUM_PRODUCTS; i++) begin
        price_r[i] <= PRICE_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRODUCT_COUNT) begin
        pcount_r <= cfg_wdata[IDX_W-1:0];
      end else begin
        price_r[IDX_W'(cfg_index - CFG_PRICE_FIRST)] <= cfg_wdata;
      end
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_data.product_index;
      paid_r <= in_data.paid_cents;
    end
  end

  // Evaluate the purchase against product count, price and the stock read back.
  always_comb begin
    if (idx_r < IDX_W'(NUM_PRODUCTS)) begin
      price_sel = price_r[idx_r];
    end else begin
      price_sel = '0;
    end
    not_found = (idx_r >= pcount_r) || (idx_r >= IDX_W'(NUM_PRODUCTS));
    refused   = (stock == '0) || (paid_r < price_sel);
    change    = paid_r - price_sel;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EVAL;
      S_EVAL: begin
        if (!not_found && !refused && change != '0) begin
          state_nxt = S_COIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_COIN: if (coin_line.valid && coin_line.last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: write back stock, start the change unit, load the result register.
  always_comb begin
    wr_en         = 1'b0;
    coin_req      = '0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    unique case (state_r)
      S_IDLE: ;
      S_EVAL: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.item_kind = KIND_STATUS;
        out_data_nxt.last      = 1'b1;
        if (not_found) begin
          out_data_nxt.status = ST_NOT_FOUND;
        end else if (refused) begin
          out_data_nxt.status = ST_REFUSED;
        end else begin
          wr_en                     = 1'b1;
          out_data_nxt.status       = ST_SUCCESS;
          out_data_nxt.change_cents = change;
          out_data_nxt.last         = (change == '0);
          coin_req.start            = (change != '0);
          coin_req.change           = change;
        end
      end
      S_COIN: begin
        out_valid_nxt           = coin_line.valid;
        out_data_nxt.item_kind  = KIND_COIN;
        out_data_nxt.status     = ST_SUCCESS;
        out_data_nxt.coin_cents = coin_line.cents;
        out_data_nxt.coin_count = coin_line.count;
        out_data_nxt.last       = coin_line.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Accepted request is evaluated in the very next cycle.
  `VPC_ASSERT_NXT(a_accept_eval, accept, state_r == S_EVAL)
  // Coin lines come only out of the change phase.
  `VPC_ASSERT_IMP(a_coin_phase, out_valid && out_data.item_kind == KIND_COIN, $past(state_r) == S_COIN)
  // Nothing follows the final result of a request right away.
  `VPC_ASSERT_NXT(a_last_quiet, out_valid && out_data.last, !out_valid)
  // A result is only produced while a request is in progress.
  `VPC_ASSERT_IMP(a_result_busy, out_valid, $past(busy))

endmodule
